// ----- src/twg_pkg.sv -----
// Shared types, command codes and reset constants for the triangle wave generator.
package twg_pkg;

   localparam int CHANNELS_DEFAULT = 3;
   localparam int CHAN_W           = 2;
   localparam int CMD_W            = 3;
   localparam int BYTE_W           = 8;
   localparam int LEVEL_W          = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK        = 3'd0,
      CMD_RESET       = 3'd1,
      CMD_TOGGLE      = 3'd2,
      CMD_SET_MAX     = 3'd3,
      CMD_SET_STEP    = 3'd4,
      CMD_SET_SINGLE  = 3'd5,
      CMD_SET_INITIAL = 3'd6
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [CHAN_W-1:0] channel;
      logic [BYTE_W-1:0] value;
      logic [BYTE_W-1:0] offset_single;
      logic [BYTE_W-1:0] offset_step;
      logic [BYTE_W-1:0] offset_max;
      logic [BYTE_W-1:0] offset_initial;
   } item_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               rising;
      logic [BYTE_W-1:0]  max_b;
      logic [BYTE_W-1:0]  step;
      logic [BYTE_W-1:0]  init_b;
      logic               single;
   } chan_state_type;

   typedef struct packed {
      logic [CHAN_W-1:0] channel_out;
      logic [BYTE_W-1:0] level;
      logic              falling;
   } result_type;

   localparam chan_state_type STATE_RESET = '{
      level:  16'h0000,
      rising: 1'b0,
      max_b:  8'hFF,
      step:   8'h80,
      init_b: 8'h00,
      single: 1'b1
   };

endpackage

// ----- src/twg_if.sv -----
// Valid/ready channel interfaces for request and response items.
interface twg_req_if;
   import twg_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     command;
   logic [CHAN_W-1:0]    channel;
   logic [BYTE_W-1:0]    value;
   logic [BYTE_W-1:0]    offset_single;
   logic [BYTE_W-1:0]    offset_step;
   logic [BYTE_W-1:0]    offset_max;
   logic [BYTE_W-1:0]    offset_initial;

   modport source (output valid, command, channel, value, offset_single, offset_step,
                   offset_max, offset_initial, input ready);
   modport sink   (input valid, command, channel, value, offset_single, offset_step,
                   offset_max, offset_initial, output ready);
endinterface

interface twg_rsp_if;
   import twg_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CHAN_W-1:0]    channel_out;
   logic [BYTE_W-1:0]    level;
   logic                 falling;

   modport source (output valid, channel_out, level, falling, input ready);
   modport sink   (input valid, channel_out, level, falling, output ready);
endinterface

// ----- src/twg_regfile.sv -----
// Per-channel state registers with one read port and one write port.
module twg_regfile #(
   parameter int CHANNELS = twg_pkg::CHANNELS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [twg_pkg::CHAN_W-1:0]    chan,
   output twg_pkg::chan_state_type       rd_state,
   input  logic                          wr_en,
   input  twg_pkg::chan_state_type       wr_state
);
   import twg_pkg::*;

   chan_state_type state_ff [CHANNELS];

   always_comb begin
      rd_state = state_ff[0];
      for (int i = 0; i < CHANNELS; i++) begin
         if (5'(i) == {3'b000, chan}) begin
            rd_state = state_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CHANNELS; i++) begin
         if (reset) begin
            state_ff[i] <= STATE_RESET;
         end else if (wr_en && (5'(i) == {3'b000, chan})) begin
            state_ff[i] <= wr_state;
         end
      end
   end

endmodule

// ----- src/twg_calc.sv -----
// Command decode and tick, reflect and reset arithmetic for one channel.
module twg_calc #(
   parameter int CHANNELS = twg_pkg::CHANNELS_DEFAULT
) (
   input  twg_pkg::item_type        item,
   input  twg_pkg::chan_state_type  cur,
   output twg_pkg::chan_state_type  nxt,
   output logic                     wr_en,
   output twg_pkg::result_type      result
);
   import twg_pkg::*;

   function automatic logic [BYTE_W-1:0] sat_add(input logic [BYTE_W-1:0] a,
                                                  input logic [BYTE_W-1:0] b);
      logic [BYTE_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[BYTE_W] ? {BYTE_W{1'b1}} : s[BYTE_W-1:0];
   endfunction

   logic                in_range;
   logic                single_eff;
   logic [BYTE_W:0]     step9;
   logic [LEVEL_W-1:0]  step16;
   logic [BYTE_W-1:0]   top_b;
   logic [BYTE_W-1:0]   init_sat;
   logic [LEVEL_W:0]    rise_sum;

   assign in_range   = {3'b000, item.channel} < 5'(CHANNELS);
   assign single_eff = item.offset_single[BYTE_W-1] ^ cur.single;
   assign step9      = {1'b0, item.offset_step} + {1'b0, cur.step};
   assign step16     = {7'b0, step9};
   assign top_b      = sat_add(cur.max_b, item.offset_max);
   assign init_sat   = sat_add(cur.init_b, item.offset_initial);
   assign rise_sum   = {1'b0, cur.level} + {1'b0, step16};

   always_comb begin
      nxt = cur;
      unique case (cmd_type'(item.command))
         CMD_TICK: begin
            if (!cur.rising && (cur.level < step16)) begin
               if (single_eff) begin
                  nxt.level = '0;
               end else begin
                  nxt.level  = step16 - cur.level;
                  nxt.rising = 1'b1;
               end
            end else if (cur.rising && (rise_sum > {1'b0, top_b, 8'h00})) begin
               nxt.level  = {top_b[BYTE_W-2:0], 9'b0} - step16 - cur.level;
               nxt.rising = 1'b0;
            end else if (cur.rising) begin
               nxt.level = rise_sum[LEVEL_W-1:0];
            end else begin
               nxt.level = cur.level - step16;
            end
         end
         CMD_RESET: begin
            nxt.level  = {((init_sat > top_b) ? top_b : init_sat), 8'h00};
            nxt.rising = 1'b1;
         end
         CMD_TOGGLE: begin
            nxt.rising = !cur.rising;
         end
         CMD_SET_MAX: begin
            nxt.max_b  = item.value;
            nxt.init_b = (cur.init_b > item.value) ? item.value : cur.init_b;
         end
         CMD_SET_STEP: begin
            nxt.step = item.value;
         end
         CMD_SET_SINGLE: begin
            nxt.single = item.value[BYTE_W-1];
         end
         CMD_SET_INITIAL: begin
            nxt.init_b = (item.value > cur.max_b) ? cur.max_b : item.value;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   assign wr_en = in_range;

   always_comb begin
      result.channel_out = item.channel;
      if (in_range) begin
         result.level   = nxt.level[LEVEL_W-1:BYTE_W];
         result.falling = !nxt.rising;
      end else begin
         result.level   = '0;
         result.falling = 1'b0;
      end
   end

endmodule

// ----- src/triangle_wave_generator.sv -----
// Top level of the multi-channel triangle wave generator.
//
//   Channel    Direction  Handshake           Payload
//   req_chan   in         valid/ready         command, channel, value, offset bytes
//   rsp_chan   out        valid/ready         channel_out, level, falling
//
// One item is accepted per cycle unless stalled; item and result are each registered.
// The item register feeds the decode and arithmetic, which update the channel state
// and load the result register in the same cycle.
// Synchronous reset clears both valid flags and returns every channel to its defaults.
// A stalled result holds; the item register then fills and ready drops.
module triangle_wave_generator #(
   parameter int CHANNELS = twg_pkg::CHANNELS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   twg_req_if.sink    req_chan,
   twg_rsp_if.source  rsp_chan
);
   import twg_pkg::*;

   logic           in_valid_ff, in_valid_in;
   item_type       item_ff, item_in;
   logic           rsp_valid_ff, rsp_valid_in;
   result_type     result_ff, result_in;

   logic           out_free;
   logic           advance;
   logic           req_take;
   chan_state_type cur_state;
   chan_state_type nxt_state;
   logic           calc_wr_en;
   result_type     calc_result;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      item_in     = item_ff;
      in_valid_in = in_valid_ff;
      if (req_take) begin
         item_in.command        = req_chan.command;
         item_in.channel        = req_chan.channel;
         item_in.value          = req_chan.value;
         item_in.offset_single  = req_chan.offset_single;
         item_in.offset_step    = req_chan.offset_step;
         item_in.offset_max     = req_chan.offset_max;
         item_in.offset_initial = req_chan.offset_initial;
         in_valid_in            = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         result_in    = calc_result;
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   twg_regfile #(
      .CHANNELS (CHANNELS)
   ) u_regfile (
      .clock    (clock),
      .reset    (reset),
      .chan     (item_ff.channel),
      .rd_state (cur_state),
      .wr_en    (advance && calc_wr_en),
      .wr_state (nxt_state)
   );

   twg_calc #(
      .CHANNELS (CHANNELS)
   ) u_calc (
      .item   (item_ff),
      .cur    (cur_state),
      .nxt    (nxt_state),
      .wr_en  (calc_wr_en),
      .result (calc_result)
   );

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.channel_out = result_ff.channel_out;
   assign rsp_chan.level       = result_ff.level;
   assign rsp_chan.falling     = result_ff.falling;

`ifndef ASSERT_OFF
   a_advance_loads_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff && (result_ff == $past(calc_result)))
      else $error("Result register did not load the processed item.");

   a_held_item_stable: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff && $stable(item_ff))
      else $error("Waiting item was overwritten.");

   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ({3'b000, result_ff.channel_out} >= 5'(CHANNELS)))
         |-> (result_ff.level == '0) && !result_ff.falling)
      else $error("Result for an absent channel is not zero.");
`endif

endmodule
